// ===== rtl/assert_macros.svh =====
// shared assertion macros for the blitter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst, prop) \
    label: assert property (@(posedge clk) disable iff (rst) prop) \
        else $error("property failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
    label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== rtl/msb_pkg.sv =====
package msb_pkg;

    localparam int SCREEN_W    = 640;
    localparam int SCREEN_H    = 400;
    localparam int SPRITE_H    = 32;
    localparam int GLYPH_COUNT = 256;

    localparam int LINE_WORDS = (SCREEN_W + 31) / 32;
    localparam int FB_WORDS   = SCREEN_H * LINE_WORDS;
    localparam int FB_AW      = $clog2(FB_WORDS);
    localparam int FONT_BYTES = GLYPH_COUNT * 8;
    localparam int FONT_AW    = $clog2(FONT_BYTES);

    localparam int IN_W   = 120;
    localparam int USER_W = 3;
    localparam int OUT_W  = 40;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // bounds on the origin, inclusive
    localparam logic [10:0] X_MAX_S32 = 11'(SCREEN_W - 32);
    localparam logic [10:0] Y_MAX_S32 = 11'(SCREEN_H - SPRITE_H);
    localparam logic [10:0] X_MAX_S64 = 11'(SCREEN_W - 64);
    localparam logic [10:0] Y_MAX_S64 = 11'(SCREEN_H - 2 * SPRITE_H);
    localparam logic [10:0] X_MAX_GLY = 11'(SCREEN_W - 9);
    localparam logic [10:0] Y_MAX_GLY = 11'(SCREEN_H - 9);

    localparam logic [2:0] REQ_SPR32 = 3'd0;
    localparam logic [2:0] REQ_SPR64 = 3'd1;
    localparam logic [2:0] REQ_GLYPH = 3'd2;
    localparam logic [2:0] REQ_FONT  = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    typedef enum logic [2:0] {
        K_NONE,
        K_PLOT,
        K_GLYPH,
        K_FONT,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               clip;
        logic [FB_AW-1:0]   waddr;
        logic [FONT_AW-1:0] faddr;
        logic [63:0]        data;
        logic [4:0]         shift;
        logic [1:0]         cnt;
    } t_cmd;

endpackage

// ===== rtl/monochrome_sprite_blitter_unit.sv =====
// channel   dir  signals                          transaction
// s_axis    in   tvalid tready tdata[119:0]       one request: tuser req_type, tdata fields
//                tuser[2:0]
// m_axis    out  tvalid tready tdata[39:0]        one result per request
//
// steps: a plot does one read then one write per in-range word it touches, a glyph
// first fetches its font byte, a frame read only reads its word; other requests go straight to the result
// reset: a clearing pass writes zero over all 8000 frame words, one per cycle;
// s_axis_tready stays low until the pass is done
// stalls: a two-entry command queue separates intake from execution, and the
// result register lets the next request run while a result waits on m_axis_tready
module monochrome_sprite_blitter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pos_x, pos_y, row_index, row_bits_lo, row_bits_hi, glyph_code, word_addr, zero pad
    input  logic [msb_pkg::IN_W-1:0]      s_axis_tdata,
    // req_type
    input  logic [msb_pkg::USER_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // read_data, clipped, zero pad
    output logic [msb_pkg::OUT_W-1:0]     m_axis_tdata
);

    msb_pkg::t_cmd front_cmd;
    msb_pkg::t_cmd head_cmd;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    logic          clearing;

    msb_front u_front (
        .i_tvalid   (s_axis_tvalid),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_tready   (s_axis_tready),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    msb_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (q_empty)
    );

    msb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_cmd      (head_cmd),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata)
    );

endmodule

// ===== rtl/msb_front.sv =====
module msb_front (
    input  logic                         i_tvalid,
    input  logic [msb_pkg::IN_W-1:0]     i_tdata,
    input  logic [msb_pkg::USER_W-1:0]   i_tuser,
    input  logic                         i_q_full,
    input  logic                         i_clearing,
    output logic                         o_tready,
    output logic                         o_push,
    output msb_pkg::t_cmd                o_cmd
);

    logic [10:0] pos_x;
    logic [10:0] pos_y;
    logic [5:0]  row;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [7:0]  code;
    logic [12:0] word_addr;
    logic [10:0] x_u;
    logic [10:0] y_u;
    logic [10:0] line;
    logic [15:0] line_base;
    logic [15:0] waddr_full;
    logic [15:0] rd_addr;
    logic        in_s32;
    logic        in_s64;
    logic        in_gly;
    logic        code_ok;
    logic        row_ok8;

    assign pos_x     = i_tdata[10:0];
    assign pos_y     = i_tdata[21:11];
    assign row       = i_tdata[27:22];
    assign lo        = i_tdata[59:28];
    assign hi        = i_tdata[91:60];
    assign code      = i_tdata[99:92];
    assign word_addr = i_tdata[112:100];

    assign x_u = {1'b0, pos_x[9:0]};
    assign y_u = {1'b0, pos_y[9:0]};
    assign line = y_u + {5'b0, row};
    assign line_base = 16'({5'b0, line}) * 16'(msb_pkg::LINE_WORDS);
    assign waddr_full = line_base + {11'b0, x_u[9:5]};
    assign rd_addr = {3'b0, word_addr};

    assign in_s32 = !pos_x[10] && (x_u <= msb_pkg::X_MAX_S32)
                 && !pos_y[10] && (y_u <= msb_pkg::Y_MAX_S32);
    assign in_s64 = !pos_x[10] && (x_u <= msb_pkg::X_MAX_S64)
                 && !pos_y[10] && (y_u <= msb_pkg::Y_MAX_S64);
    assign in_gly = !pos_x[10] && (x_u <= msb_pkg::X_MAX_GLY)
                 && !pos_y[10] && (y_u <= msb_pkg::Y_MAX_GLY);
    assign code_ok = {1'b0, code} < 9'(msb_pkg::GLYPH_COUNT);
    assign row_ok8 = (row[5:3] == 3'b0);

    assign o_tready = !i_q_full && !i_clearing;
    assign o_push   = i_tvalid && o_tready;

    always_comb begin
        o_cmd       = '0;
        o_cmd.kind  = msb_pkg::K_NONE;
        o_cmd.waddr = waddr_full[msb_pkg::FB_AW-1:0];
        o_cmd.faddr = msb_pkg::FONT_AW'({code, row[2:0]});
        o_cmd.data  = {lo, 32'h0};
        o_cmd.shift = x_u[4:0];
        o_cmd.cnt   = 2'd2;
        case (i_tuser)
            msb_pkg::REQ_SPR32: begin
                if (!in_s32) begin
                    o_cmd.clip = 1'b1;
                end else if ({1'b0, row} < 7'(msb_pkg::SPRITE_H)) begin
                    o_cmd.kind = msb_pkg::K_PLOT;
                end
            end
            msb_pkg::REQ_SPR64: begin
                o_cmd.data = {lo, hi};
                o_cmd.cnt  = 2'd3;
                if (!in_s64) begin
                    o_cmd.clip = 1'b1;
                end else if ({1'b0, row} < 7'(2 * msb_pkg::SPRITE_H)) begin
                    o_cmd.kind = msb_pkg::K_PLOT;
                end
            end
            msb_pkg::REQ_GLYPH: begin
                if (!in_gly) begin
                    o_cmd.clip = 1'b1;
                end else if (row_ok8 && code_ok) begin
                    o_cmd.kind = msb_pkg::K_GLYPH;
                end
            end
            msb_pkg::REQ_FONT: begin
                o_cmd.data = {56'h0, lo[7:0]};
                if (row_ok8 && code_ok) begin
                    o_cmd.kind = msb_pkg::K_FONT;
                end
            end
            msb_pkg::REQ_READ: begin
                o_cmd.waddr = rd_addr[msb_pkg::FB_AW-1:0];
                o_cmd.cnt   = 2'd1;
                if (rd_addr < 16'(msb_pkg::FB_WORDS)) begin
                    o_cmd.kind = msb_pkg::K_READ;
                end
            end
            default: begin
                o_cmd.kind = msb_pkg::K_NONE;
            end
        endcase
    end

endmodule

// ===== rtl/msb_fifo.sv =====
`include "assert_macros.svh"

module msb_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  msb_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output msb_pkg::t_cmd o_data,
    output logic          o_empty
);

    msb_pkg::t_cmd                r_mem [msb_pkg::QDEPTH];
    logic [msb_pkg::QAW-1:0]      r_wp;
    logic [msb_pkg::QAW-1:0]      r_rp;
    logic [msb_pkg::QCW-1:0]      r_cnt;
    logic [msb_pkg::QCW-1:0]      n_cnt;

    assign o_full  = (r_cnt == msb_pkg::QCW'(msb_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    `ASSERT_NEVER(a_push_full, i_clk, !i_rst_n, i_push && o_full && !i_pop)
    `ASSERT_NEVER(a_pop_empty, i_clk, !i_rst_n, i_pop && o_empty)

endmodule

// ===== rtl/msb_back.sv =====
`include "assert_macros.svh"

module msb_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_empty,
    input  msb_pkg::t_cmd             i_cmd,
    output logic                      o_pop,
    output logic                      o_clearing,
    output logic                      o_tvalid,
    input  logic                      i_tready,
    output logic [msb_pkg::OUT_W-1:0] o_tdata
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_FONT  = 6'b000100,
        S_RD    = 6'b001000,
        S_WR    = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    msb_pkg::t_cmd               r_cmd;
    msb_pkg::t_cmd               n_cmd;
    logic [1:0]                  r_idx;
    logic [1:0]                  n_idx;
    logic [31:0]                 r_rd;
    logic [31:0]                 n_rd;
    logic [msb_pkg::FB_AW-1:0]   r_clr;
    logic [msb_pkg::FB_AW-1:0]   n_clr;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [msb_pkg::OUT_W-1:0]   r_out_data;
    logic [msb_pkg::OUT_W-1:0]   n_out_data;

    logic [31:0]                 r_fb [msb_pkg::FB_WORDS];
    logic [31:0]                 r_fb_q;
    logic [7:0]                  r_font [msb_pkg::FONT_BYTES];
    logic [7:0]                  r_font_q;

    logic [msb_pkg::FB_AW:0]     cur_addr;
    logic                        cur_in;
    logic [95:0]                 win;
    logic [31:0]                 win_word;
    logic [1:0]                  idx_nx;
    logic                        last_word;
    logic                        out_free;
    logic                        fb_we;
    logic [msb_pkg::FB_AW-1:0]   fb_waddr;
    logic [31:0]                 fb_wdata;
    logic                        font_we;

    assign cur_addr  = {1'b0, r_cmd.waddr} + (msb_pkg::FB_AW + 1)'(r_idx);
    assign cur_in    = cur_addr < (msb_pkg::FB_AW + 1)'(msb_pkg::FB_WORDS);
    assign win       = {r_cmd.data, 32'h0} >> r_cmd.shift;
    assign idx_nx    = r_idx + 2'd1;
    assign last_word = (idx_nx == r_cmd.cnt);
    assign out_free  = !r_out_valid || i_tready;

    always_comb begin
        case (r_idx)
            2'd0:    win_word = win[95:64];
            2'd1:    win_word = win[63:32];
            default: win_word = win[31:0];
        endcase
    end

    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_tvalid   = r_out_valid;
    assign o_tdata    = r_out_data;

    assign fb_we    = (r_state == S_CLEAR)
                   || ((r_state == S_WR) && (r_cmd.kind != msb_pkg::K_READ));
    assign fb_waddr = (r_state == S_CLEAR) ? r_clr : cur_addr[msb_pkg::FB_AW-1:0];
    assign fb_wdata = (r_state == S_CLEAR) ? 32'h0 : (r_fb_q | win_word);
    assign font_we  = o_pop && (i_cmd.kind == msb_pkg::K_FONT);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_rd        = r_rd;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !i_tready;
        n_out_data  = r_out_data;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == msb_pkg::FB_AW'(msb_pkg::FB_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_cmd = i_cmd;
                    n_idx = 2'd0;
                    n_rd  = 32'h0;
                    case (i_cmd.kind)
                        msb_pkg::K_PLOT:  n_state = S_RD;
                        msb_pkg::K_READ:  n_state = S_RD;
                        msb_pkg::K_GLYPH: n_state = S_FONT;
                        default:          n_state = S_DONE;
                    endcase
                end
            end
            S_FONT: begin
                // glyph byte sits at the top so the bit shift places it in its byte lane
                n_cmd.data = {r_font_q, 56'h0};
                n_state    = S_RD;
            end
            S_RD: begin
                if (cur_in) begin
                    n_state = S_WR;
                end else if (last_word) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = idx_nx;
                end
            end
            S_WR: begin
                if (r_cmd.kind == msb_pkg::K_READ) begin
                    n_rd = r_fb_q;
                end
                if (last_word) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = idx_nx;
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'h0, r_cmd.clip, r_rd};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_rd       <= n_rd;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            r_fb[fb_waddr] <= fb_wdata;
        end
        r_fb_q <= r_fb[cur_addr[msb_pkg::FB_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (font_we) begin
            r_font[i_cmd.faddr] <= i_cmd.data[7:0];
        end
        r_font_q <= r_font[i_cmd.faddr];
    end

    `ASSERT_PROP(a_no_pop_clear, i_clk, !i_rst_n, (r_state == S_CLEAR) |-> !o_pop)
    `ASSERT_PROP(a_idx_in_run, i_clk, !i_rst_n, (r_state == S_RD) |-> (r_idx < r_cmd.cnt))
    `ASSERT_PROP(a_read_done, i_clk, !i_rst_n,
        ((r_state == S_WR) && (r_cmd.kind == msb_pkg::K_READ)) |=> (r_state == S_DONE))
    `ASSERT_NEVER(a_wr_in_range, i_clk, !i_rst_n, (r_state == S_WR) && !cur_in)

endmodule

// ===== tb/monochrome_sprite_blitter_unit_checker.sv =====
`timescale 1ns / 1ps

module monochrome_sprite_blitter_unit_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    // pos_x, pos_y, row_index, row_bits_lo, row_bits_hi, glyph_code, word_addr, zero pad
    input  logic [msb_pkg::IN_W-1:0]   i_s_tdata,
    // req_type
    input  logic [msb_pkg::USER_W-1:0] i_s_tuser,
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    // read_data, clipped, zero pad
    input  logic [msb_pkg::OUT_W-1:0]  i_m_tdata,
    output int                         o_results_owed,
    output int                         o_mismatches
);

    localparam int IN_W        = msb_pkg::IN_W;
    localparam int SCREEN_W    = msb_pkg::SCREEN_W;
    localparam int SCREEN_H    = msb_pkg::SCREEN_H;
    localparam int SPRITE_H    = msb_pkg::SPRITE_H;
    localparam int GLYPH_COUNT = msb_pkg::GLYPH_COUNT;
    localparam int LINE_WORDS  = msb_pkg::LINE_WORDS;
    localparam int FB_WORDS    = msb_pkg::FB_WORDS;
    localparam int FONT_BYTES  = msb_pkg::FONT_BYTES;

    localparam logic [2:0] REQ_SPR32 = msb_pkg::REQ_SPR32;
    localparam logic [2:0] REQ_SPR64 = msb_pkg::REQ_SPR64;
    localparam logic [2:0] REQ_GLYPH = msb_pkg::REQ_GLYPH;
    localparam logic [2:0] REQ_FONT  = msb_pkg::REQ_FONT;
    localparam logic [2:0] REQ_READ  = msb_pkg::REQ_READ;

    localparam int GLYPH_W    = 8;
    localparam int GLYPH_ROWS = 8;

    typedef struct packed {
        logic [31:0] read_data;
        logic        clipped;
    } t_blit_result;

    // two-state copies start out all zero
    bit [31:0]    frame_copy [FB_WORDS];
    bit [7:0]     font_copy [FONT_BYTES];
    t_blit_result owed_results [$];
    int           mismatch_count;
    int           result_count;

    function automatic void or_frame_word(int idx, logic [31:0] bits);
        if (idx >= 0 && idx < FB_WORDS) frame_copy[idx] |= bits;
    endfunction

    // byte 0 of a word is its top byte
    function automatic void or_frame_byte(int bidx, logic [31:0] bits);
        or_frame_word(bidx / 4, (bits & 32'hFF) << ((3 - bidx % 4) * 8));
    endfunction

    // applies one request to the frame and font copies, returns the result it owes
    function automatic t_blit_result blit_request(logic [2:0] req, logic [IN_W-1:0] fields);
        int           x, y, span, tall, scan_line, w, s, b, fi;
        logic [5:0]   row;
        logic [31:0]  lo, hi, f;
        logic [7:0]   code;
        logic [12:0]  addr;
        t_blit_result res;
        x    = $signed(fields[10:0]);
        y    = $signed(fields[21:11]);
        row  = fields[27:22];
        lo   = fields[59:28];
        hi   = fields[91:60];
        code = fields[99:92];
        addr = fields[112:100];
        res  = '0;
        case (req)
            REQ_SPR32, REQ_SPR64: begin
                span = (req == REQ_SPR32) ? 32 : 64;
                tall = (req == REQ_SPR32) ? SPRITE_H : 2 * SPRITE_H;
                if (x < 0 || x > SCREEN_W - span || y < 0 || y > SCREEN_H - tall) begin
                    res.clipped = 1'b1;
                end else if (row < tall) begin
                    scan_line = y + row;
                    w = scan_line * LINE_WORDS + x / 32;
                    s = x % 32;
                    or_frame_word(w, lo >> s);
                    if (s != 0) or_frame_word(w + 1, lo << (32 - s));
                    if (req == REQ_SPR64) begin
                        or_frame_word(w + 1, hi >> s);
                        if (s != 0) or_frame_word(w + 2, hi << (32 - s));
                    end
                end
            end
            REQ_GLYPH: begin
                if (x < 0 || x >= SCREEN_W - GLYPH_W || y < 0 || y >= SCREEN_H - GLYPH_W) begin
                    res.clipped = 1'b1;
                end else if (row < GLYPH_ROWS && code < GLYPH_COUNT) begin
                    fi = code * GLYPH_ROWS + row;
                    f = {24'h0, font_copy[fi]};
                    scan_line = y + row;
                    b = scan_line * LINE_WORDS * 4 + x / GLYPH_W;
                    s = x % GLYPH_W;
                    or_frame_byte(b, f >> s);
                    if (s != 0) or_frame_byte(b + 1, f << (GLYPH_W - s));
                end
            end
            REQ_FONT: begin
                if (row < GLYPH_ROWS && code < GLYPH_COUNT) begin
                    fi = code * GLYPH_ROWS + row;
                    font_copy[fi] = lo[7:0];
                end
            end
            REQ_READ: begin
                if (addr < FB_WORDS) res.read_data = frame_copy[addr];
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic flag_result(string why, t_blit_result want, t_blit_result got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t result %0d %s: expected %h/%b, got %h/%b",
                     $realtime, result_count, why, want.read_data, want.clipped,
                     got.read_data, got.clipped);
    endtask

    always @(posedge i_clk) begin : watch
        t_blit_result got, want;
        if (i_rst_n === 1'b1) begin
            if (i_s_tvalid === 1'b1 && i_s_tready === 1'b1)
                owed_results.push_back(blit_request(i_s_tuser, i_s_tdata));
            if (i_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
                got.read_data = i_m_tdata[31:0];
                got.clipped   = i_m_tdata[32];
                if (owed_results.size() == 0) begin
                    flag_result("with nothing owed", '0, got);
                end else begin
                    want = owed_results.pop_front();
                    if (got.read_data !== want.read_data || got.clipped !== want.clipped)
                        flag_result("differs", want, got);
                end
                result_count++;
            end
        end
        o_results_owed <= owed_results.size();
        o_mismatches   <= mismatch_count;
    end

endmodule

// ===== tb/monochrome_sprite_blitter_unit_test.sv =====
`timescale 1ns / 1ps

module monochrome_sprite_blitter_unit_test;

    localparam int IN_W       = msb_pkg::IN_W;
    localparam int USER_W     = msb_pkg::USER_W;
    localparam int OUT_W      = msb_pkg::OUT_W;
    localparam int SCREEN_W   = msb_pkg::SCREEN_W;
    localparam int SCREEN_H   = msb_pkg::SCREEN_H;
    localparam int SPRITE_H   = msb_pkg::SPRITE_H;
    localparam int LINE_WORDS = msb_pkg::LINE_WORDS;
    localparam int FB_WORDS   = msb_pkg::FB_WORDS;
    localparam int FONT_BYTES = msb_pkg::FONT_BYTES;

    localparam logic [2:0] REQ_SPR32 = msb_pkg::REQ_SPR32;
    localparam logic [2:0] REQ_SPR64 = msb_pkg::REQ_SPR64;
    localparam logic [2:0] REQ_GLYPH = msb_pkg::REQ_GLYPH;
    localparam logic [2:0] REQ_FONT  = msb_pkg::REQ_FONT;
    localparam logic [2:0] REQ_READ  = msb_pkg::REQ_READ;

    localparam int GLYPH_W       = 8;
    localparam int GLYPH_ROWS    = 8;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int QUIET_ITEMS   = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 30;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int MAX_ADDR      = (1 << 13) - 1;

    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic [USER_W-1:0] s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    int  results_owed;
    int  mismatches;
    int  items_sent = 0;
    int  cycle_count = 0;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_armed = 1'b0;
    bit  font_loaded [FONT_BYTES];
    int  loaded_fonts [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    monochrome_sprite_blitter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    monochrome_sprite_blitter_unit_checker result_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tuser      (s_axis_tuser),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .o_results_owed (results_owed),
        .o_mismatches   (mismatches)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("monochrome_sprite_blitter_unit_test: done, errors");
            $finish;
        end
    end

    function automatic bit glyph_reads_font(int x, int y, int row);
        return x >= 0 && x < SCREEN_W - GLYPH_W && y >= 0 && y < SCREEN_H - GLYPH_W
               && row < GLYPH_ROWS;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 2047)) - 1024;
    endfunction

    function automatic logic [31:0] pixel_pattern();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic int idle_choice();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    task automatic send_request(input logic [2:0] req, input int x, input int y,
                                input int row, input logic [31:0] lo, input logic [31:0] hi,
                                input int code, input int addr);
        int font_idx;
        // a glyph plot may only fetch font bytes that were loaded before
        if (req == REQ_GLYPH && glyph_reads_font(x, y, row)) begin
            font_idx = code * GLYPH_ROWS + row;
            if (!font_loaded[font_idx]) begin
                font_idx = loaded_fonts[$urandom_range(0, loaded_fonts.size() - 1)];
                code = font_idx / GLYPH_ROWS;
                row  = font_idx % GLYPH_ROWS;
            end
        end
        if (req == REQ_FONT && row < GLYPH_ROWS) begin
            font_idx = code * GLYPH_ROWS + row;
            if (!font_loaded[font_idx]) begin
                font_loaded[font_idx] = 1'b1;
                loaded_fonts.push_back(font_idx);
            end
        end
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {7'h0, 13'(addr), 8'(code), hi, lo, 6'(row), 11'(y), 11'(x)};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        items_sent++;
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
    endtask

    task automatic read_word(input int addr);
        send_request(REQ_READ, rand_coord(), rand_coord(), $urandom_range(0, 63), $urandom,
                     $urandom, $urandom_range(0, 255), addr);
    endtask

    task automatic directed_requests();
        send_request(REQ_FONT, 0, 0, 7, 32'hFFFF_FFA5, '0, 255, 0);
        send_request(REQ_FONT, -1024, 1023, 0, 32'h0000_0081, '1, 0, MAX_ADDR);
        // font rows past the glyph load nothing
        send_request(REQ_FONT, 0, 0, 8, 32'h0000_00FF, '0, 3, 0);
        send_request(REQ_FONT, 0, 0, 63, 32'h0000_00FF, '0, 3, 0);
        send_request(REQ_SPR32, 0, 0, 0, '1, '0, 0, 0);
        send_request(REQ_SPR32, SCREEN_W - 32, SCREEN_H - SPRITE_H, SPRITE_H - 1,
                     32'h8000_0001, '0, 0, 0);
        send_request(REQ_SPR32, SCREEN_W - 31, 0, 0, '1, '0, 0, 0);
        send_request(REQ_SPR32, -1, 0, 0, '1, '0, 0, 0);
        send_request(REQ_SPR32, 5, -1024, 0, '1, '0, 0, 0);
        send_request(REQ_SPR32, 5, 0, 63, '1, '1, 0, 0);
        send_request(REQ_SPR64, SCREEN_W - 64, SCREEN_H - 2 * SPRITE_H, 63, '1, '1, 0, 0);
        send_request(REQ_SPR64, 33, 10, 0, 32'hF000_0001, 32'h8000_000F, 0, 0);
        send_request(REQ_SPR64, SCREEN_W - 63, 0, 0, '1, '1, 0, 0);
        send_request(REQ_SPR64, 0, SCREEN_H - 2 * SPRITE_H + 1, 0, '1, '1, 0, 0);
        send_request(REQ_GLYPH, SCREEN_W - GLYPH_W - 1, SCREEN_H - GLYPH_W - 1, 7,
                     '0, '0, 255, 0);
        send_request(REQ_GLYPH, SCREEN_W - GLYPH_W, 0, 0, '0, '0, 0, 0);
        send_request(REQ_GLYPH, 0, SCREEN_H - GLYPH_W, 0, '0, '0, 0, 0);
        send_request(REQ_GLYPH, 0, 0, 0, '0, '0, 0, 0);
        // glyph row past the shape draws nothing
        send_request(REQ_GLYPH, 3, 0, 8, '0, '0, 17, 0);
        read_word(0);
        read_word(FB_WORDS - 1);
        read_word(FB_WORDS);
        read_word(MAX_ADDR);
        read_word(10 * LINE_WORDS + 1);
        send_request(REQ_SPARE_FIRST, 1023, -1, 63, '1, '1, 255, MAX_ADDR);
        send_request(REQ_SPARE_LAST, 1023, -1, 63, '1, '1, 255, MAX_ADDR);
    endtask

    task automatic sprite_run(input logic [2:0] req);
        int span, tall, x, y, row0, rows;
        span = (req == REQ_SPR32) ? 32 : 64;
        tall = (req == REQ_SPR32) ? SPRITE_H : 2 * SPRITE_H;
        if ($urandom_range(0, 9) == 0) begin
            x = rand_coord();
            y = rand_coord();
        end else begin
            x = $urandom_range(0, SCREEN_W - span);
            y = $urandom_range(0, SCREEN_H - tall);
            if ($urandom_range(0, 3) == 0) x = x - x % 32;
        end
        row0 = $urandom_range(0, tall - 1);
        rows = $urandom_range(1, 8);
        for (int r = row0; r < row0 + rows; r++)
            send_request(req, x, y, r % 64, pixel_pattern(), pixel_pattern(),
                         $urandom_range(0, 255), $urandom_range(0, MAX_ADDR));
        if (x >= 0 && y >= 0 && x <= SCREEN_W - span && y <= SCREEN_H - tall)
            for (int k = 0; k <= span / 32; k++)
                read_word((y + row0) * LINE_WORDS + x / 32 + k);
    endtask

    task automatic glyph_run();
        int code, x, y;
        code = $urandom_range(0, 255);
        if ($urandom_range(0, 1) == 0)
            for (int r = 0; r < GLYPH_ROWS; r++)
                send_request(REQ_FONT, rand_coord(), rand_coord(), r, $urandom, $urandom, code,
                             $urandom_range(0, MAX_ADDR));
        if ($urandom_range(0, 9) == 0) begin
            x = rand_coord();
            y = rand_coord();
        end else begin
            x = $urandom_range(0, SCREEN_W - GLYPH_W - 1);
            y = $urandom_range(0, SCREEN_H - GLYPH_W - 1);
        end
        for (int r = 0; r < GLYPH_ROWS; r++)
            send_request(REQ_GLYPH, x, y,
                         ($urandom_range(0, 15) == 0) ? $urandom_range(GLYPH_ROWS, 63) : r,
                         $urandom, $urandom, code, $urandom_range(0, MAX_ADDR));
        if (glyph_reads_font(x, y, 0)) begin
            read_word(y * LINE_WORDS + x / 32);
            read_word((y + GLYPH_ROWS - 1) * LINE_WORDS + (x + GLYPH_W - 1) / 32);
        end
    endtask

    // ready side: random stalls, plus one long hold-off that backs up the input
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int  next_segment;
        int  random_end;
        bit  paused;
        paused = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 20;
        rx_idle_pct <= 20;
        directed_requests();
        wait_for_results();
        random_end   = items_sent + RANDOM_ITEMS;
        next_segment = items_sent;
        while (items_sent < random_end) begin
            if (items_sent >= random_end - QUIET_ITEMS) begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end else if (items_sent >= next_segment) begin
                next_segment = items_sent + 100;
                tx_idle_pct = idle_choice();
                rx_idle_pct <= idle_choice();
            end
            if (items_sent >= 300) hold_armed <= 1'b1;
            if (!paused && items_sent >= 700) begin
                paused = 1'b1;
                wait_for_results();
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5:   sprite_run(REQ_SPR32);
                6, 7, 8, 9, 10:     sprite_run(REQ_SPR64);
                11, 12, 13:         glyph_run();
                14, 15, 16:
                    send_request(3'($urandom_range(0, 7)), rand_coord(), rand_coord(),
                                 $urandom_range(0, 63), $urandom, $urandom,
                                 $urandom_range(0, 255), $urandom_range(0, MAX_ADDR));
                default:
                    read_word(($urandom_range(0, 9) == 0) ? $urandom_range(FB_WORDS, MAX_ADDR)
                                                          : $urandom_range(0, FB_WORDS - 1));
            endcase
        end
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_owed == 0)
            $display("monochrome_sprite_blitter_unit_test: done, clean");
        else
            $display("monochrome_sprite_blitter_unit_test: done, errors");
        $finish;
    end

endmodule
